@@ rtl/lrupr_pkg.sv @@
package lrupr_pkg;

    // fixed field widths of the ports
    localparam int PAGE_W = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 5;

    // frames_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } t_state;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic update;   // apply the registered lookup result
        logic age_all;  // miss: age every valid frame
        logic clear;    // drop valid bits and ranks
    } t_cell_ctl;

endpackage

@@ rtl/lrupr_cell.sv @@
module lrupr_cell #(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16,
    parameter int RANK_W      = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrupr_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_active,
    input  logic                  i_prev_valid,
    input  logic [PAGE_BITS-1:0]  i_req_page,
    input  logic [RANK_W-1:0]     i_last_rank,
    input  logic [RANK_W-1:0]     i_limit,
    input  logic                  i_sel,
    output logic                  o_valid,
    output logic                  o_match,
    output logic                  o_empty_first,
    output logic                  o_lru,
    output logic [PAGE_BITS-1:0]  o_page,
    output logic [RANK_W-1:0]     o_rank
);

    localparam logic [RANK_W-1:0] RankMax = RANK_W'(FRAME_COUNT - 1);

    logic                 r_valid;
    logic                 n_valid;
    logic [RANK_W-1:0]    r_rank;
    logic [RANK_W-1:0]    n_rank;
    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;

    // lookup flags; the fill target is the first empty frame after a valid neighbor
    assign o_match       = i_active && r_valid && (r_page == i_req_page);
    assign o_empty_first = i_active && !r_valid && i_prev_valid;
    assign o_lru         = i_active && r_valid && (r_rank == i_last_rank);
    assign o_valid       = r_valid;
    assign o_page        = r_page;
    assign o_rank        = r_rank;

    // fill, touch and aging
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_page  = r_page;
        if (i_ctl.update) begin
            if (i_sel) begin
                n_page  = i_req_page;
                n_valid = 1'b1;
                n_rank  = '0;
            end else if (r_valid && (i_ctl.age_all || (r_rank < i_limit)) &&
                         (r_rank != RankMax)) begin
                n_rank = r_rank + 1'b1;
            end
        end
        if (i_ctl.clear) begin
            n_valid = 1'b0;
            n_rank  = '0;
        end
    end

    // valid and rank registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // page register
    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

@@ rtl/lrupr_chain.sv @@
module lrupr_chain #(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16,
    parameter int RANK_W      = 4,
    parameter int IDX_W       = 4,
    parameter int N_W         = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrupr_pkg::t_cell_ctl   i_ctl,
    input  logic [N_W-1:0]         i_active_count,
    input  logic [RANK_W-1:0]      i_last_rank,
    input  logic [PAGE_BITS-1:0]   i_req_page,
    input  logic [RANK_W-1:0]      i_limit,
    input  logic [FRAME_COUNT-1:0] i_sel,
    output logic                   o_hit,
    output logic                   o_evict,
    output logic [FRAME_COUNT-1:0] o_sel,
    output logic [IDX_W-1:0]       o_idx,
    output logic [RANK_W-1:0]      o_hit_rank,
    output logic [PAGE_BITS-1:0]   o_ev_page
);

    logic [FRAME_COUNT-1:0] valid;
    logic [FRAME_COUNT-1:0] prev_valid;
    logic [FRAME_COUNT-1:0] active;
    logic [FRAME_COUNT-1:0] match;
    logic [FRAME_COUNT-1:0] empty_first;
    logic [FRAME_COUNT-1:0] lru;
    logic [PAGE_BITS-1:0]   page [FRAME_COUNT];
    logic [RANK_W-1:0]      rank [FRAME_COUNT];
    logic                   any_empty;

    // row of cells
    for (genvar j = 0; j < FRAME_COUNT; j++) begin : g_cell
        assign active[j] = (32'(i_active_count) > j);

        // each cell sees the valid bit of its lower neighbor
        if (j == 0) begin : g_first
            assign prev_valid[j] = 1'b1;
        end else begin : g_next
            assign prev_valid[j] = valid[j-1];
        end

        lrupr_cell #(
            .FRAME_COUNT (FRAME_COUNT),
            .PAGE_BITS   (PAGE_BITS),
            .RANK_W      (RANK_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (i_ctl),
            .i_active      (active[j]),
            .i_prev_valid  (prev_valid[j]),
            .i_req_page    (i_req_page),
            .i_last_rank   (i_last_rank),
            .i_limit       (i_limit),
            .i_sel         (i_sel[j]),
            .o_valid       (valid[j]),
            .o_match       (match[j]),
            .o_empty_first (empty_first[j]),
            .o_lru         (lru[j]),
            .o_page        (page[j]),
            .o_rank        (rank[j])
        );
    end

    // frame choice: resident page, else first empty frame, else oldest frame
    assign o_hit     = |match;
    assign any_empty = |empty_first;
    assign o_evict   = !o_hit && !any_empty;
    assign o_sel     = o_hit ? match : (any_empty ? empty_first : lru);

    // one-hot reductions of index, rank and evicted page
    always_comb begin
        o_idx      = '0;
        o_hit_rank = '0;
        o_ev_page  = '0;
        for (int j = 0; j < FRAME_COUNT; j++) begin
            if (o_sel[j]) begin
                o_idx = o_idx | IDX_W'(j);
            end
            if (match[j]) begin
                o_hit_rank = o_hit_rank | rank[j];
            end
            if (lru[j] && o_evict) begin
                o_ev_page = o_ev_page | page[j];
            end
        end
    end

endmodule

@@ rtl/lru_page_replacement_top.sv @@
// LRU page replacement unit, a fully associative row of page frames.
// Request channel: i_in_valid with i_page and i_end_of_string; the item is
// taken at a clock edge where i_in_valid is high and o_in_stall is low.
// Result channel: o_out_valid with hit, frame index, evicted page and the
// running hit and miss totals; taken where o_out_valid is high and
// i_out_stall is low.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data writes
// frames_in_use; any write empties the table and clears both totals.
// Each item passes a lookup step, the match and victim search across the cell
// row, then an update step that writes the ranks and loads the output register;
// the next item is taken during the update step, not before it.
// An end-of-string item is answered normally, then table and totals clear.
// Reset (i_rst_n low, synchronous): frames_in_use is 3, all frames empty,
// totals zero, no result pending.
// While the receiver stalls, a finished result holds in the output register
// and the following item waits in the update step; no further request is taken.
module lru_page_replacement_top #(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]   i_page,
    input  logic                           i_end_of_string,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_hit,
    output logic [lrupr_pkg::IDX_W-1:0]    o_frame_index,
    output logic                           o_evicted_valid,
    output logic [lrupr_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic [lrupr_pkg::CNT_W-1:0]    o_hit_total,
    output logic [lrupr_pkg::CNT_W-1:0]    o_miss_total
);

    localparam int RankW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int IdxW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int NW    = $clog2(FRAME_COUNT + 1);
    localparam int CntW  = lrupr_pkg::CNT_W;

    lrupr_pkg::t_state    r_state;
    lrupr_pkg::t_state    n_state;
    lrupr_pkg::t_cell_ctl ctl;

    logic [lrupr_pkg::CFG_W-1:0] r_frames;
    logic [PAGE_BITS-1:0]        r_req_page;
    logic                        r_eos;
    logic [FRAME_COUNT-1:0]      r_sel;
    logic                        r_hit;
    logic                        r_evict;
    logic [IdxW-1:0]             r_idx;
    logic [RankW-1:0]            r_limit;
    logic [PAGE_BITS-1:0]        r_ev_page;
    logic [CntW-1:0]             r_hit_count;
    logic [CntW-1:0]             r_miss_count;
    logic [CntW-1:0]             n_hit_count;
    logic [CntW-1:0]             n_miss_count;

    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lrupr_pkg::IDX_W-1:0] r_out_idx;
    logic                        r_out_ev_valid;
    logic [lrupr_pkg::PAGE_W-1:0] r_out_ev_page;
    logic [CntW-1:0]             r_out_hit_total;
    logic [CntW-1:0]             r_out_miss_total;

    logic                        in_ready;
    logic                        in_accept;
    logic                        cfg_accept;
    logic                        out_free;
    logic                        look;
    logic                        do_update;
    logic [31:0]                 frames_ext;
    logic [31:0]                 active32;
    logic [31:0]                 last32;
    logic [31:0]                 page_ext;
    logic [31:0]                 ev_ext;
    logic [31:0]                 idx_ext;

    logic                        c_hit;
    logic                        c_evict;
    logic [FRAME_COUNT-1:0]      c_sel;
    logic [IdxW-1:0]             c_idx;
    logic [RankW-1:0]            c_hit_rank;
    logic [PAGE_BITS-1:0]        c_ev_page;

    // active frame count: zero acts as one, oversize acts as the full row
    always_comb begin
        frames_ext = 32'(r_frames);
        if (frames_ext == 32'd0) begin
            active32 = 32'd1;
        end else if (frames_ext > 32'(FRAME_COUNT)) begin
            active32 = 32'(FRAME_COUNT);
        end else begin
            active32 = frames_ext;
        end
        last32 = active32 - 32'd1;
    end

    // page width adaption on both sides
    assign page_ext = 32'(i_page);
    assign ev_ext   = 32'(r_ev_page);
    assign idx_ext  = 32'(r_idx);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_accept  = i_in_valid && in_ready;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;
    assign o_in_stall = !in_ready;

    // sequencer: take, look up, update
    always_comb begin
        n_state     = r_state;
        in_ready    = 1'b0;
        o_cfg_ready = 1'b0;
        look        = 1'b0;
        do_update   = 1'b0;
        case (r_state)
            lrupr_pkg::ST_IDLE: begin
                o_cfg_ready = 1'b1;
                in_ready    = !i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    n_state = lrupr_pkg::ST_LOOK;
                end
            end
            lrupr_pkg::ST_LOOK: begin
                look    = 1'b1;
                n_state = lrupr_pkg::ST_UPDATE;
            end
            lrupr_pkg::ST_UPDATE: begin
                if (out_free) begin
                    do_update = 1'b1;
                    in_ready  = 1'b1;
                    n_state   = i_in_valid ? lrupr_pkg::ST_LOOK : lrupr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    // cell row control
    always_comb begin
        ctl.update  = do_update;
        ctl.age_all = !r_hit;
        ctl.clear   = cfg_accept || (do_update && r_eos);
    end

    lrupr_chain #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS),
        .RANK_W      (RankW),
        .IDX_W       (IdxW),
        .N_W         (NW)
    ) u_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_active_count (active32[NW-1:0]),
        .i_last_rank    (last32[RankW-1:0]),
        .i_req_page     (r_req_page),
        .i_limit        (r_limit),
        .i_sel          (r_sel),
        .o_hit          (c_hit),
        .o_evict        (c_evict),
        .o_sel          (c_sel),
        .o_idx          (c_idx),
        .o_hit_rank     (c_hit_rank),
        .o_ev_page      (c_ev_page)
    );

    // saturating totals including this item
    always_comb begin
        n_hit_count  = r_hit_count;
        n_miss_count = r_miss_count;
        if (r_hit) begin
            if (r_hit_count != {CntW{1'b1}}) begin
                n_hit_count = r_hit_count + 1'b1;
            end
        end else begin
            if (r_miss_count != {CntW{1'b1}}) begin
                n_miss_count = r_miss_count + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lrupr_pkg::ST_IDLE;
            r_frames     <= lrupr_pkg::CFG_RESET;
            r_hit_count  <= '0;
            r_miss_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_accept) begin
                r_frames     <= i_cfg_data;
                r_hit_count  <= '0;
                r_miss_count <= '0;
            end else if (do_update) begin
                r_hit_count  <= r_eos ? '0 : n_hit_count;
                r_miss_count <= r_eos ? '0 : n_miss_count;
            end
            if (do_update) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, lookup result and output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_page <= page_ext[PAGE_BITS-1:0];
            r_eos      <= i_end_of_string;
        end
        if (look) begin
            r_sel     <= c_sel;
            r_hit     <= c_hit;
            r_evict   <= c_evict;
            r_idx     <= c_idx;
            r_limit   <= c_hit_rank;
            r_ev_page <= c_ev_page;
        end
        if (do_update) begin
            r_out_hit        <= r_hit;
            r_out_idx        <= idx_ext[lrupr_pkg::IDX_W-1:0];
            r_out_ev_valid   <= r_evict;
            r_out_ev_page    <= ev_ext[lrupr_pkg::PAGE_W-1:0];
            r_out_hit_total  <= n_hit_count;
            r_out_miss_total <= n_miss_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_idx;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_hit_total     = r_out_hit_total;
    assign o_miss_total    = r_out_miss_total;

endmodule

@@ test/lru_page_replacement_checker.sv @@
module lru_page_replacement_checker #(
    parameter int FRAME_COUNT = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [lrupr_pkg::PAGE_W-1:0]   i_page,
    input  logic                           i_end_of_string,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_hit,
    input  logic [lrupr_pkg::IDX_W-1:0]    i_frame_index,
    input  logic                           i_evicted_valid,
    input  logic [lrupr_pkg::PAGE_W-1:0]   i_evicted_page,
    input  logic [lrupr_pkg::CNT_W-1:0]    i_hit_total,
    input  logic [lrupr_pkg::CNT_W-1:0]    i_miss_total,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic                         hit;
        logic [lrupr_pkg::IDX_W-1:0]  frame_index;
        logic                         evicted_valid;
        logic [lrupr_pkg::PAGE_W-1:0] evicted_page;
        logic [lrupr_pkg::CNT_W-1:0]  hit_total;
        logic [lrupr_pkg::CNT_W-1:0]  miss_total;
    } t_access_result;

    localparam int NO_AGE_LIMIT = 32'h7fff_ffff;

    // shadow copy of the frame table
    logic [lrupr_pkg::CFG_W-1:0]  frames_cfg;
    logic [lrupr_pkg::PAGE_W-1:0] page_of [FRAME_COUNT];
    logic                         resident [FRAME_COUNT];
    int                           age_of [FRAME_COUNT];
    logic [lrupr_pkg::CNT_W-1:0]  hits;
    logic [lrupr_pkg::CNT_W-1:0]  misses;

    t_access_result    access_q [$];
    int                mismatches;

    function automatic int active_frames();
        if (frames_cfg == '0) begin
            return 1;
        end
        if (int'(frames_cfg) > FRAME_COUNT) begin
            return FRAME_COUNT;
        end
        return int'(frames_cfg);
    endfunction

    function automatic logic [lrupr_pkg::CNT_W-1:0] bump(logic [lrupr_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic clear_table();
        for (int j = 0; j < FRAME_COUNT; j++) begin
            resident[j] = 1'b0;
            age_of[j]   = 0;
        end
        hits   = '0;
        misses = '0;
    endtask

    // age younger resident frames, then make idx the newest
    task automatic make_newest(int n, int idx, int limit);
        for (int j = 0; j < n; j++) begin
            if (j != idx && resident[j] && age_of[j] < limit &&
                age_of[j] < FRAME_COUNT - 1) begin
                age_of[j]++;
            end
        end
        age_of[idx] = 0;
    endtask

    task automatic predict_access(input logic [lrupr_pkg::PAGE_W-1:0] page, input logic last,
                                  output t_access_result r);
        int   n;
        int   idx;
        int   oldest;
        logic found;
        logic got_empty;
        n         = active_frames();
        idx       = 0;
        found     = 1'b0;
        got_empty = 1'b0;
        r         = '0;

        // lowest-numbered resident match wins
        for (int j = 0; j < n; j++) begin
            if (!found && resident[j] && page_of[j] == page) begin
                found = 1'b1;
                idx   = j;
            end
        end

        if (found) begin
            make_newest(n, idx, age_of[idx]);
            hits = bump(hits);
        end else begin
            for (int j = 0; j < n; j++) begin
                if (!got_empty && !resident[j]) begin
                    got_empty = 1'b1;
                    idx       = j;
                end
            end
            // no empty frame: evict the oldest, lowest index on a tie
            if (!got_empty) begin
                oldest = age_of[0];
                idx    = 0;
                for (int j = 1; j < n; j++) begin
                    if (age_of[j] > oldest) begin
                        oldest = age_of[j];
                        idx    = j;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = page_of[idx];
            end
            make_newest(n, idx, NO_AGE_LIMIT);
            page_of[idx]  = page;
            resident[idx] = 1'b1;
            misses        = bump(misses);
        end

        r.hit         = found;
        r.frame_index = idx[lrupr_pkg::IDX_W-1:0];
        r.hit_total   = hits;
        r.miss_total  = misses;
        if (last) begin
            clear_table();
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        t_access_result want;
        t_access_result got;
        if (!i_rst_n) begin
            frames_cfg = lrupr_pkg::CFG_RESET;
            clear_table();
            access_q.delete();
            mismatches = 0;
        end else begin
            // results first: a result leaving now belongs to an older item
            if (i_out_valid && !i_out_stall) begin
                got = '{i_hit, i_frame_index, i_evicted_valid, i_evicted_page,
                        i_hit_total, i_miss_total};
                if (access_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"unexpected result: hit=%0d frame=%0d ",
                                  "evict=%0d/%h hits=%0d misses=%0d"},
                                 got.hit, got.frame_index, got.evicted_valid,
                                 got.evicted_page, got.hit_total, got.miss_total);
                    end
                end else begin
                    want = access_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch at %0t:", $realtime);
                            $display({"  expected hit=%0d frame=%0d ",
                                      "evict=%0d/%h hits=%0d misses=%0d"},
                                     want.hit, want.frame_index, want.evicted_valid,
                                     want.evicted_page, want.hit_total, want.miss_total);
                            $display({"  actual   hit=%0d frame=%0d ",
                                      "evict=%0d/%h hits=%0d misses=%0d"},
                                     got.hit, got.frame_index, got.evicted_valid,
                                     got.evicted_page, got.hit_total, got.miss_total);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                frames_cfg = i_cfg_data;
                clear_table();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_access(i_page, i_end_of_string, want);
                access_q.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= access_q.size();
    end

endmodule

@@ test/lru_page_replacement_top_test.sv @@
module lru_page_replacement_top_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;
    localparam int CfgW        = lrupr_pkg::CFG_W;
    localparam int PageW       = lrupr_pkg::PAGE_W;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic [CfgW-1:0]     i_cfg_data      = '0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [PageW-1:0]    i_page          = '0;
    logic                i_end_of_string = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic                o_hit;
    logic [lrupr_pkg::IDX_W-1:0] o_frame_index;
    logic                o_evicted_valid;
    logic [PageW-1:0]    o_evicted_page;
    logic [lrupr_pkg::CNT_W-1:0] o_hit_total;
    logic [lrupr_pkg::CNT_W-1:0] o_miss_total;

    int fail_count;
    int pending_results;
    int cycle_count   = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 61;

    lru_page_replacement_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page          (i_page),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total)
    );

    lru_page_replacement_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_page          (i_page),
        .i_end_of_string (i_end_of_string),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_hit           (o_hit),
        .i_frame_index   (o_frame_index),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_hit_total     (o_hit_total),
        .i_miss_total    (o_miss_total),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[lru_page_replacement_top] ERROR");
            $finish;
        end
    end

    // present one request item, leave valid high once it is taken
    task automatic send_request(input logic [PageW-1:0] page, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_page          <= page;
        i_end_of_string <= last;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [CfgW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int               cfg_plan [14];
        logic [CfgW-1:0]  cfg_value;
        logic [PageW-1:0] page_pool [$];
        logic [PageW-1:0] page;
        int               frame_total;
        int               pool_size;
        int               phase_items;
        int               sent;

        cfg_plan = '{16, 1, 4, 2, 8, 31, 5, 0, 12, 17, 3, 16, -1, -1};
        sent     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size of three frames, fills, hits, evictions, end of string
        send_request(16'h0000, 1'b0);
        send_request(16'hffff, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'h8000, 1'b0);
        send_request(16'h0001, 1'b0);
        send_request(16'h0000, 1'b0);
        send_request(16'hffff, 1'b0);
        send_request(16'h5555, 1'b1);
        send_request(16'h5555, 1'b0);
        drain_results();

        // rewriting the same size still empties the table
        write_frames(5'd3);
        send_request(16'h5555, 1'b0);
        send_request(16'h5555, 1'b0);
        drain_results();

        // zero frames behaves as one
        write_frames(5'd0);
        send_request(16'h0007, 1'b0);
        send_request(16'h0008, 1'b0);
        send_request(16'h0008, 1'b0);
        drain_results();

        // sizes above the frame count clamp
        write_frames(5'd31);
        send_request(16'haaaa, 1'b0);
        send_request(16'h5555, 1'b0);
        send_request(16'haaaa, 1'b1);
        drain_results();
        write_frames(5'd17);
        send_request(16'h1234, 1'b0);
        send_request(16'hedcb, 1'b0);
        drain_results();

        // random phases, each with its own size and a pool of reused pages
        foreach (cfg_plan[p]) begin
            cfg_value = (cfg_plan[p] < 0) ? CfgW'($urandom_range(0, 31))
                                          : CfgW'(cfg_plan[p]);
            write_frames(cfg_value);
            frame_total = (cfg_value == '0) ? 1 :
                          ((cfg_value > 5'd16) ? 16 : int'(cfg_value));
            pool_size = frame_total + $urandom_range(0, frame_total + 1);
            page_pool.delete();
            for (int k = 0; k < pool_size; k++) begin
                if ($urandom_range(3) == 0) begin
                    page_pool.push_back(PageW'($urandom_range(0, 31)));
                end else begin
                    page_pool.push_back(PageW'($urandom_range(0, 65535)));
                end
            end
            phase_items = $urandom_range(80, 120);
            for (int k = 0; k < phase_items; k++) begin
                // sender and receiver idling by thirds of the random part
                if (sent < 467) begin
                    send_idle_pct = 25;
                    recv_idle_pct = 61;
                end else if (sent < 934) begin
                    send_idle_pct = 61;
                    recv_idle_pct = 25;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if ($urandom_range(99) < 85) begin
                    page = page_pool[$urandom_range(0, pool_size - 1)];
                end else begin
                    page = PageW'($urandom_range(0, 65535));
                end
                send_request(page, $urandom_range(99) < 3);
                sent++;
            end
            drain_results();
        end

        if (fail_count == 0 && pending_results == 0) begin
            $display("[lru_page_replacement_top] OK");
        end else begin
            $display("[lru_page_replacement_top] ERROR");
        end
        $finish;
    end

endmodule
